// ===== src/three_phase_sine_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-phase sine generator
// Implication checks on the rising clock edge, muted while reset is active.
// ----------------------------------------------------------------------------
`ifndef THREE_PHASE_SINE_GENERATOR_ASSERT_SVH
`define THREE_PHASE_SINE_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPSG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tpsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsg_pkg
// Sizes, register map, item types and the cosine table builder shared by the
// three-phase sine generator.
// ----------------------------------------------------------------------------
package tpsg_pkg;

	// Sizes of the datapath.
	localparam int QUARTER_DEPTH = 1024;
	localparam int ANGLE_DEPTH   = 4096;
	localparam int ACC_BITS      = 32;
	localparam int SAMPLE_BITS   = 16;
	localparam int ANGLE_OUT_BITS = 16;
	localparam int NUM_PHASES    = 3;

	localparam int QUARTER_BITS = $clog2(QUARTER_DEPTH);
	localparam int PHASE_BITS   = QUARTER_BITS + 2;
	localparam int ANGLE_BITS   = $clog2(ANGLE_DEPTH);
	localparam int OFFSET_BITS  = 12;
	localparam int MOD_BITS     = 16;
	localparam int PROD_BITS    = 2 * SAMPLE_BITS;

	// Angle slope: pi in Q48, and the shift that brings the product to Q3.13.
	localparam int PI_BITS = 51;
	localparam logic signed [PI_BITS-1:0] PI_Q48 = 51'sh3243F6A8885A3;
	localparam int ANGLE_SHIFT = 35 + ANGLE_BITS;
	localparam int APROD_BITS  = PI_BITS + ANGLE_BITS + 1;

	// Register map.
	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;
	localparam logic [1:0] REG_OFFSET_A = 2'd0;
	localparam logic [1:0] REG_OFFSET_B = 2'd1;
	localparam logic [1:0] REG_OFFSET_C = 2'd2;

	localparam logic [OFFSET_BITS-1:0] OFFSET_A_RESET = 12'd0;
	localparam logic [OFFSET_BITS-1:0] OFFSET_B_RESET = 12'd2731;
	localparam logic [OFFSET_BITS-1:0] OFFSET_C_RESET = 12'd1365;

	// Phase offsets handed from the register block to the datapath.
	typedef struct packed {
		logic [OFFSET_BITS-1:0] offset_phase_a;
		logic [OFFSET_BITS-1:0] offset_phase_b;
		logic [OFFSET_BITS-1:0] offset_phase_c;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic signed [ANGLE_OUT_BITS-1:0] angle;
		logic signed [SAMPLE_BITS-1:0]    sample_a;
		logic signed [SAMPLE_BITS-1:0]    sample_b;
		logic signed [SAMPLE_BITS-1:0]    sample_c;
	} out_item_t;

	// Quarter-wave cosine table; entries never exceed the positive maximum.
	typedef logic [SAMPLE_BITS-2:0] cos_table_t [QUARTER_DEPTH];

	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

	// Upper bits of a Q62 by Q62 product.
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// Restoring long division of unsigned 64-bit values, one quotient bit per step.
	function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Taylor series of the cosine in Q62, scaled down to the sample format.
	function automatic cos_table_t build_cos_table();
		cos_table_t tbl;
		logic [63:0] half;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		logic [63:0] maxv;
		half = PI_Q62 >> 1;
		maxv = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
		for (int i = 0; i < QUARTER_DEPTH; i++) begin
			x = (half / QUARTER_DEPTH) * 64'(i) + ((half % QUARTER_DEPTH) * 64'(i)) / QUARTER_DEPTH;
			x2 = mul_q62(x, x);
			term = 64'd1 << 62;
			sum = term;
			for (int k = 1; k < 40 && term != 64'd0; k++) begin
				term = div_u64(mul_q62(term, x2), 64'(2 * k - 1) * 64'(2 * k));
				if (k % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			v = sum >> (62 - (SAMPLE_BITS - 1));
			tbl[i] = (v > maxv) ? maxv[SAMPLE_BITS-2:0] : v[SAMPLE_BITS-2:0];
		end
		return tbl;
	endfunction

endpackage

// ===== src/tpsg_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsg_in_if
// Input channel: phase increment and modulation index with valid/ready.
// ----------------------------------------------------------------------------
interface tpsg_in_if import tpsg_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [ACC_BITS-1:0]        phase_increment;
	logic signed [MOD_BITS-1:0] mod_index;

	modport source (output valid, output phase_increment, output mod_index, input ready);
	modport sink (input valid, input phase_increment, input mod_index, output ready);
endinterface

// ===== src/tpsg_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsg_out_if
// Output channel: angle and three scaled samples with valid/ready.
// ----------------------------------------------------------------------------
interface tpsg_out_if import tpsg_pkg::*;;
	logic                             valid;
	logic                             ready;
	logic signed [ANGLE_OUT_BITS-1:0] angle;
	logic signed [SAMPLE_BITS-1:0]    sample_a;
	logic signed [SAMPLE_BITS-1:0]    sample_b;
	logic signed [SAMPLE_BITS-1:0]    sample_c;

	modport source (output valid, output angle, output sample_a, output sample_b,
		output sample_c, input ready);
	modport sink (input valid, input angle, input sample_a, input sample_b,
		input sample_c, output ready);
endinterface

// ===== src/tpsg_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsg_cfg_regs
// APB register block holding the three phase offsets.
// ----------------------------------------------------------------------------
module tpsg_cfg_regs import tpsg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// Register writes; the unused fourth slot ignores writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_phase_a <= OFFSET_A_RESET;
			cfg_q.offset_phase_b <= OFFSET_B_RESET;
			cfg_q.offset_phase_c <= OFFSET_C_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_OFFSET_A: cfg_q.offset_phase_a <= pwdata[OFFSET_BITS-1:0];
				REG_OFFSET_B: cfg_q.offset_phase_b <= pwdata[OFFSET_BITS-1:0];
				REG_OFFSET_C: cfg_q.offset_phase_c <= pwdata[OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_OFFSET_A: prdata = CFG_DATA_BITS'(cfg_q.offset_phase_a);
			REG_OFFSET_B: prdata = CFG_DATA_BITS'(cfg_q.offset_phase_b);
			REG_OFFSET_C: prdata = CFG_DATA_BITS'(cfg_q.offset_phase_c);
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== src/tpsg_cos_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsg_cos_rom
// Quarter-wave cosine ROM with one registered read port.
// ----------------------------------------------------------------------------
module tpsg_cos_rom import tpsg_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic [QUARTER_BITS-1:0] addr,
	output logic [SAMPLE_BITS-2:0]  data
);

	localparam cos_table_t ROM = build_cos_table();

	logic [SAMPLE_BITS-2:0] data_q;

	// Synchronous read, held while the pipeline stalls.
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= ROM[addr];
		end
	end

	assign data = data_q;

endmodule

// ===== src/tpsg_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsg_out_stage
// Output register with a skid register, so the pipeline keeps moving for one
// more item while a result waits.
// ----------------------------------------------------------------------------
module tpsg_out_stage import tpsg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	input  out_item_t         up_item,
	output logic              up_ready,
	tpsg_out_if.source        dout
);

	logic      out_valid_q;
	logic      skid_valid_q;
	out_item_t out_item_q;
	out_item_t skid_item_q;
	logic      push;

	assign up_ready = !skid_valid_q;
	assign push     = up_valid && up_ready;

	// Control: the skid register fills only when the output register is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (dout.ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !dout.ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (dout.ready) begin
				out_item_q <= skid_item_q;
			end
		end else if (push) begin
			if (out_valid_q && !dout.ready) begin
				skid_item_q <= up_item;
			end else begin
				out_item_q <= up_item;
			end
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.angle    = out_item_q.angle;
	assign dout.sample_a = out_item_q.sample_a;
	assign dout.sample_b = out_item_q.sample_b;
	assign dout.sample_c = out_item_q.sample_c;

endmodule

// ===== src/three_phase_sine_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_phase_sine_generator
// Direct digital synthesis of three offset sine waves scaled by a modulation
// index, plus the angle of the phase a quarter turn ahead.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake        Payload
//  din      in   valid / ready    phase_increment[31:0], mod_index[15:0]
//  dout     out  valid / ready    angle, sample_a, sample_b, sample_c [15:0]
//  apb      in   psel / penable   paddr[3:0], pwdata / prdata [31:0]
//
//  One item per clock cycle while din.ready is high; an accepted item passes
//  the cosine ROM read, the multipliers and the output register in turn.
//  The cosine ROM has three copies, one read port per phase output.
//  Reset clears the accumulator, the stage valid bits and the output stage,
//  and loads the default offsets.
//  A stalled output holds one item in a skid register; the pipeline and the
//  input stop only once that register is occupied.
//
module three_phase_sine_generator import tpsg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	tpsg_in_if.sink                  din,
	tpsg_out_if.source               dout,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready
);

`include "three_phase_sine_generator_assert.svh"

	cfg_t                         cfg;
	logic                         en;
	logic                         accept;
	logic [ACC_BITS-1:0]          acc_q;
	logic [ACC_BITS-1:0]          acc_next;
	logic [PHASE_BITS-1:0]        phase;
	logic [ANGLE_BITS-1:0]        angle_k;
	logic [OFFSET_BITS-1:0]       offs [NUM_PHASES];

	logic                         v_s1;
	logic                         v_s2;
	logic signed [MOD_BITS-1:0]   mod_s1;
	logic signed [ANGLE_BITS:0]   am_s1;
	logic signed [APROD_BITS-1:0] aprod_s2;
	logic signed [PROD_BITS-1:0]  prod_s2 [NUM_PHASES];
	out_item_t                    res_item;

	// Register block.
	tpsg_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign offs[0] = cfg.offset_phase_a;
	assign offs[1] = cfg.offset_phase_b;
	assign offs[2] = cfg.offset_phase_c;

	assign din.ready = en;
	assign accept    = din.valid && en;

	// Accumulator update; the new value drives this item's phase.
	assign acc_next = acc_q + din.phase_increment;
	assign phase    = acc_next[ACC_BITS-1 -: PHASE_BITS];
	assign angle_k  = ANGLE_BITS'(phase) + ANGLE_BITS'(ANGLE_DEPTH / 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else if (en) begin
			if (din.valid) begin
				acc_q <= acc_next;
			end
			v_s1 <= din.valid;
			v_s2 <= v_s1;
		end
	end

	// Shared stage registers: index and the angle multiplier operand 2k - n.
	always_ff @(posedge clk) begin
		if (en) begin
			mod_s1   <= din.mod_index;
			am_s1    <= {~angle_k[ANGLE_BITS-1], angle_k[ANGLE_BITS-2:0], 1'b0};
			aprod_s2 <= APROD_BITS'(PI_Q48) * APROD_BITS'(am_s1);
		end
	end

	// One lane per phase output: fold, ROM read, sign and scale.
	for (genvar g = 0; g < NUM_PHASES; g++) begin : g_lane
		logic [PHASE_BITS-1:0]         sum;
		logic [1:0]                    quad;
		logic [QUARTER_BITS-1:0]       r;
		logic [QUARTER_BITS-1:0]       addr;
		logic                          zero;
		logic                          zero_s1;
		logic                          neg_s1;
		logic [SAMPLE_BITS-2:0]        rom_s1;
		logic signed [SAMPLE_BITS-1:0] mag;
		logic signed [SAMPLE_BITS-1:0] sine;

		// Quadrant folding into the quarter-wave table.
		always_comb begin
			sum  = phase + offs[g];
			quad = sum[PHASE_BITS-1 -: 2];
			r    = sum[QUARTER_BITS-1:0];
			addr = quad[0] ? r : QUARTER_BITS'(0) - r;
			zero = !quad[0] && (r == '0);
		end

		tpsg_cos_rom u_rom (
			.clk  (clk),
			.en   (en),
			.addr (addr),
			.data (rom_s1)
		);

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s1 <= zero;
				neg_s1  <= quad[1];
			end
		end

		// Signed sine value, then the scaling product.
		always_comb begin
			mag  = zero_s1 ? '0 : $signed({1'b0, rom_s1});
			sine = neg_s1 ? -mag : mag;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s2[g] <= PROD_BITS'(mod_s1) * PROD_BITS'(sine);
			end
		end
	end

	// Floor scaling of the products into the result item.
	always_comb begin
		res_item.angle    = ANGLE_OUT_BITS'(aprod_s2 >>> ANGLE_SHIFT);
		res_item.sample_a = SAMPLE_BITS'(prod_s2[0] >>> (SAMPLE_BITS - 1));
		res_item.sample_b = SAMPLE_BITS'(prod_s2[1] >>> (SAMPLE_BITS - 1));
		res_item.sample_c = SAMPLE_BITS'(prod_s2[2] >>> (SAMPLE_BITS - 1));
	end

	// Output register and skid.
	tpsg_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s2),
		.up_item  (res_item),
		.up_ready (en),
		.dout     (dout)
	);

	// Pipeline checks.
	`TPSG_ASSERT_NEXT(a_acc_hold, clk, arst_n, !accept, $stable(acc_q), "accumulator moved without an item")
	`TPSG_ASSERT_NEXT(a_s1_fill, clk, arst_n, accept, v_s1, "accepted item missing from stage one")
	`TPSG_ASSERT_NEXT(a_s2_fill, clk, arst_n, v_s1 && en, v_s2, "item lost between stage one and two")
	`TPSG_ASSERT_NEXT(a_s2_hold, clk, arst_n, v_s2 && !en, v_s2, "stalled item dropped in stage two")
	`TPSG_ASSERT_SAME(a_stall_out, clk, arst_n, !en, dout.valid, "pipeline stalled with no result shown")

endmodule
